// ----- design/ring_deque_with_search_macros.svh -----
// Assertion macros for the ring deque block.
// Taken in by the top level only; needs no package.
`ifndef RING_DEQUE_WITH_SEARCH_MACROS_SVH
`define RING_DEQUE_WITH_SEARCH_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, quiet during reset
`define RDS_CHECK_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ring deque check failed: same-cycle rule");

// Next-cycle implication, quiet during reset
`define RDS_CHECK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ring deque check failed: next-cycle rule");

`else

`define RDS_CHECK_IMPLY(label, clk, rst, ante, cons)
`define RDS_CHECK_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- design/rds_pkg.sv -----
// Shared types and codes for the ring deque block.
// No dependencies; used by rds_ctrl, rds_dp, ring_deque_with_search and tb_top.
package rds_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int ACTION_BITS = 3;
  localparam int STATUS_BITS = 2;

  typedef logic [ACTION_BITS-1:0] action_t;
  typedef logic [STATUS_BITS-1:0] status_t;

  // Action codes carried in each input word
  localparam action_t ACT_PUSH_FRONT = 3'd0;
  localparam action_t ACT_PUSH_BACK  = 3'd1;
  localparam action_t ACT_POP_FRONT  = 3'd2;
  localparam action_t ACT_POP_BACK   = 3'd3;
  localparam action_t ACT_SEARCH     = 3'd4;

  // Result status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;
  localparam status_t ST_MISS  = 2'd3;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_OUT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture the incoming word
    logic exec;   // apply the captured action
    logic scan;   // advance the search by one step
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_scan;  // captured action is a search over a non-empty store
    logic scan_done;  // search has found a match or run past the back
  } sts_t;

endpackage

// ----- design/rds_ctrl.sv -----
// Controller state machine for the ring deque block.
// Depends on rds_pkg for the state, command and status types.
module rds_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output rds_pkg::cmd_t cmd,
  input  rds_pkg::sts_t sts
);
  import rds_pkg::*;

  state_t state, state_next;
  logic   take;

  // Take a new word when idle, or as the waiting result leaves
  assign take = in_valid && !in_stall;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = sts.need_scan ? S_SCAN : S_OUT;
      end
      S_SCAN: begin
        if (sts.scan_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_next = in_valid ? S_EXEC : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall  = !((state == S_IDLE) || ((state == S_OUT) && !out_stall));
    out_valid = (state == S_OUT);
    cmd.load  = take;
    cmd.exec  = (state == S_EXEC);
    cmd.scan  = (state == S_SCAN);
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- design/rds_dp.sv -----
// Datapath for the ring deque block: ring memory, front index, count,
// search scan and result registers. Depends on rds_pkg.
module rds_dp #(
  parameter int DEPTH     = 64,
  parameter int DATA_BITS = 32,
  parameter int CW        = $clog2(DEPTH + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rds_pkg::cmd_t                       cmd,
  output rds_pkg::sts_t                       sts,
  input  rds_pkg::action_t                    action,
  input  logic signed [rds_pkg::VALUE_BITS-1:0] value,
  output rds_pkg::status_t                    status,
  output logic [CW-1:0]                       position,
  output logic [CW-1:0]                       fill
);
  import rds_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_INDEX = AW'(DEPTH - 1);

  // Ring memory
  logic [DATA_BITS-1:0] mem [DEPTH];
  logic [DATA_BITS-1:0] rd_data;

  // Control state
  logic [AW-1:0] front, front_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] scan_idx;
  logic          cmp_valid;

  // Captured word and scan payload
  action_t              act;
  logic [DATA_BITS-1:0] key;
  logic [CW-1:0]        cmp_pos;

  // Result registers
  status_t       res_status;
  logic [CW-1:0] res_pos;
  logic [CW-1:0] res_fill;

  logic          is_full, is_empty;
  logic [AW-1:0] front_dec, front_inc, back_addr, rd_addr, wr_addr;
  logic          wr_en, issue, hit, miss;
  status_t       exec_status;

  // Index base plus offset, folded once into the ring
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  // Ring addressing
  assign is_full   = (count == FULL_COUNT);
  assign is_empty  = (count == '0);
  assign front_dec = (front == '0) ? LAST_INDEX : front - 1'b1;
  assign front_inc = wrap_add(front, CW'(1));
  assign back_addr = wrap_add(front, count);
  assign rd_addr   = wrap_add(front, scan_idx);

  // Apply the captured action
  always_comb begin
    front_next  = front;
    count_next  = count;
    wr_en       = 1'b0;
    wr_addr     = back_addr;
    exec_status = ST_OK;
    unique case (act)
      ACT_PUSH_FRONT: begin
        if (is_full) begin
          exec_status = ST_FULL;
        end else begin
          front_next = front_dec;
          count_next = count + 1'b1;
          wr_en      = cmd.exec;
          wr_addr    = front_dec;
        end
      end
      ACT_PUSH_BACK: begin
        if (is_full) begin
          exec_status = ST_FULL;
        end else begin
          count_next = count + 1'b1;
          wr_en      = cmd.exec;
        end
      end
      ACT_POP_FRONT: begin
        if (is_empty) begin
          exec_status = ST_EMPTY;
        end else begin
          front_next = front_inc;
          count_next = count - 1'b1;
        end
      end
      ACT_POP_BACK: begin
        if (is_empty) begin
          exec_status = ST_EMPTY;
        end else begin
          count_next = count - 1'b1;
        end
      end
      ACT_SEARCH: begin
        if (is_empty) exec_status = ST_EMPTY;
      end
      default: exec_status = ST_OK;
    endcase
  end

  // Scan one element a cycle: read ahead, compare what came back
  assign issue = cmd.scan && (scan_idx != count);
  assign hit   = cmp_valid && (rd_data == key);
  assign miss  = !cmp_valid && (scan_idx == count);

  assign sts.need_scan = (act == ACT_SEARCH) && !is_empty;
  assign sts.scan_done = hit || miss;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      count     <= '0;
      scan_idx  <= '0;
      cmp_valid <= 1'b0;
    end else if (cmd.exec) begin
      front     <= front_next;
      count     <= count_next;
      scan_idx  <= '0;
      cmp_valid <= 1'b0;
    end else if (cmd.scan) begin
      if (issue) scan_idx <= scan_idx + 1'b1;
      cmp_valid <= issue;
    end
  end

  // Payload and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= action;
      key <= DATA_BITS'(value);
    end
    if (issue) cmp_pos <= scan_idx + 1'b1;
    if (cmd.exec) begin
      res_status <= exec_status;
      res_pos    <= '0;
      res_fill   <= count_next;
    end else if (cmd.scan && hit) begin
      res_status <= ST_OK;
      res_pos    <= cmp_pos;
    end else if (cmd.scan && miss) begin
      res_status <= ST_MISS;
      res_pos    <= '0;
    end
  end

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= key;
    if (issue) rd_data <= mem[rd_addr];
  end

  assign status   = res_status;
  assign position = res_pos;
  assign fill     = res_fill;

endmodule

// ----- design/ring_deque_with_search.sv -----
// Bounded double-ended queue held in a ring memory, with a linear search from
// the front. Every accepted word gives exactly one result word. A push, a pop,
// an unknown action or any action on an empty store offers its result once the
// execute state has applied it. A search offers its result once the scan state
// reaches the first match, or runs past the back element when there is none.
// The single read port of the ring memory delivers one element a cycle while
// the scan runs. One word is in work at a time; the next word is taken in the
// cycle the waiting result leaves. The memory needs no clearing after reset.
module ring_deque_with_search #(
  parameter int DEPTH     = 64,
  parameter int DATA_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  rds_pkg::action_t                      action,
  input  logic signed [rds_pkg::VALUE_BITS-1:0] value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output rds_pkg::status_t                      status,
  output logic [$clog2(DEPTH+1)-1:0]            position,
  output logic [$clog2(DEPTH+1)-1:0]            fill
);
  import rds_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  cmd_t cmd;
  sts_t sts;

  // Sequencing
  rds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Storage, scan and results
  rds_dp #(
    .DEPTH     (DEPTH),
    .DATA_BITS (DATA_BITS),
    .CW        (CW)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .action   (action),
    .value    (value),
    .status   (status),
    .position (position),
    .fill     (fill)
  );

`include "ring_deque_with_search_macros.svh"

  // Result consistency checks
  `RDS_CHECK_IMPLY(a_fill_range, clk, rst, out_valid, fill <= CW'(DEPTH))
  `RDS_CHECK_IMPLY(a_full_fill, clk, rst, out_valid && (status == ST_FULL), fill == CW'(DEPTH))
  `RDS_CHECK_IMPLY(a_empty_fill, clk, rst, out_valid && (status == ST_EMPTY), fill == '0)
  `RDS_CHECK_IMPLY(a_pos_ok, clk, rst, out_valid && (position != '0), (status == ST_OK) && (position <= fill))
  `RDS_CHECK_NEXT(a_no_early_result, clk, rst, in_valid && !in_stall, !out_valid)

endmodule

// ----- dv/tb_top.sv -----
// Self-checking bench for the ring deque with search: drives actions, predicts
// each result from its own shadow ring, and compares status, position and fill.
// Depends on rds_pkg and the ring_deque_with_search top level.
module tb_top;
  import rds_pkg::*;

  localparam int DEPTH         = 64;
  localparam int CNT_BITS      = $clog2(DEPTH + 1);
  localparam int RANDOM_ITEMS  = 1550;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = DEPTH + 10;
  localparam int REPORT_MAX    = 10;

  // action codes the block ignores
  localparam action_t ACT_SPARE_5 = 3'd5;
  localparam action_t ACT_SPARE_6 = 3'd6;
  localparam action_t ACT_SPARE_7 = 3'd7;

  typedef logic signed [VALUE_BITS-1:0] word_t;

  typedef struct packed {
    status_t               status;
    logic [CNT_BITS-1:0]   position;
    logic [CNT_BITS-1:0]   fill;
  } result_t;

  logic                clk;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  action_t             action    = ACT_PUSH_FRONT;
  word_t               value     = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  status_t             status;
  logic [CNT_BITS-1:0] position;
  logic [CNT_BITS-1:0] fill;

  // shadow copy of the deque
  word_t       shadow_ring [DEPTH];
  int unsigned head_idx = 0;
  int unsigned elem_cnt = 0;

  result_t     pending_results [$];
  int          mismatch_count  = 0;
  int          cycle_count     = 0;
  int          burst_left      = 0;

  // receiver stall pattern state
  int          stall_mode      = 0;
  int          stall_phase_cnt = 0;

  ring_deque_with_search #(
    .DEPTH     (DEPTH),
    .DATA_BITS (VALUE_BITS)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .position  (position),
    .fill      (fill)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Apply one action to the shadow deque and return the result it gives
  function automatic result_t deque_apply(action_t act, word_t v);
    result_t     r;
    int unsigned i;
    logic        found;
    r.status   = ST_OK;
    r.position = '0;
    found      = 1'b0;
    case (act)
      ACT_PUSH_FRONT: begin
        if (elem_cnt >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          head_idx = (head_idx + DEPTH - 1) % DEPTH;
          shadow_ring[head_idx] = v;
          elem_cnt++;
        end
      end
      ACT_PUSH_BACK: begin
        if (elem_cnt >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_ring[(head_idx + elem_cnt) % DEPTH] = v;
          elem_cnt++;
        end
      end
      ACT_POP_FRONT: begin
        if (elem_cnt == 0) begin
          r.status = ST_EMPTY;
        end else begin
          head_idx = (head_idx + 1) % DEPTH;
          elem_cnt--;
        end
      end
      ACT_POP_BACK: begin
        if (elem_cnt == 0) r.status = ST_EMPTY;
        else elem_cnt--;
      end
      ACT_SEARCH: begin
        if (elem_cnt == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_MISS;
          // scan from the front, back element included
          for (i = 0; i < elem_cnt && !found; i++) begin
            if (shadow_ring[(head_idx + i) % DEPTH] == v) begin
              found      = 1'b1;
              r.status   = ST_OK;
              r.position = CNT_BITS'(i + 1);
            end
          end
        end
      end
      default: ;
    endcase
    r.fill = CNT_BITS'(elem_cnt);
    return r;
  endfunction

  // Random value: full range, a narrow band for duplicates, or an extreme
  function automatic word_t rand_value();
    case ($urandom_range(0, 3))
      0:       return word_t'($urandom_range(0, 8)) - 4;
      1:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return word_t'($urandom);
    endcase
  endfunction

  // Key that is mostly present in the store, often the back element
  function automatic word_t pick_key();
    int unsigned idx;
    if (elem_cnt == 0 || $urandom_range(0, 9) < 3) return rand_value();
    idx = ($urandom_range(0, 4) == 0) ? elem_cnt - 1 : $urandom_range(0, elem_cnt - 1);
    return shadow_ring[(head_idx + idx) % DEPTH];
  endfunction

  // Send one word; called just after a rising edge. Works in bursts with gaps.
  task automatic send_word(action_t act, word_t v);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    action   <= act;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(deque_apply(act, v));
    burst_left--;
  endtask

  // Check each result word against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    logic    bad;
    if (!rst && out_valid && !out_stall) begin
      bad  = 1'b0;
      want = '0;
      if (pending_results.size() == 0) begin
        bad = 1'b1;
      end else begin
        want = pending_results.pop_front();
        bad  = (status !== want.status) || (position !== want.position) ||
               (fill !== want.fill);
      end
      if (bad) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
          $display("mismatch at cycle %0d: expected st=%0d pos=%0d fill=%0d%s, got st=%0d pos=%0d fill=%0d",
                   cycle_count, want.status, want.position, want.fill,
                   pending_results.size() == 0 && want == '0 ? " (none waiting)" : "",
                   status, position, fill);
        end
      end
    end
  end

  // Receiver stall pattern: free-running, random, or periodic, phase by phase
  always @(posedge clk) begin
    if (stall_phase_cnt == 0) begin
      stall_mode      <= $urandom_range(0, 2);
      stall_phase_cnt <= $urandom_range(64, 400);
    end else begin
      stall_phase_cnt <= stall_phase_cnt - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= (cycle_count % 13) < 5;
    endcase
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Empty store: pops, search and the ignored actions
  task automatic test_empty_store();
    send_word(ACT_POP_FRONT, 32'sh0);
    send_word(ACT_POP_BACK, 32'sh7fffffff);
    send_word(ACT_SEARCH, 32'sh80000000);
    send_word(ACT_SPARE_5, 32'sh7fffffff);
    send_word(ACT_SPARE_6, 32'sh80000000);
    send_word(ACT_SPARE_7, -32'sd1);
  endtask

  // Each action with extreme values, searches for front, back, duplicate, miss
  task automatic test_basic_actions();
    send_word(ACT_PUSH_FRONT, 32'sh7fffffff);
    send_word(ACT_PUSH_BACK, 32'sh80000000);
    send_word(ACT_PUSH_FRONT, -32'sd1);
    send_word(ACT_PUSH_BACK, 32'sh0);
    send_word(ACT_PUSH_BACK, -32'sd1);
    send_word(ACT_SEARCH, -32'sd1);
    send_word(ACT_SEARCH, 32'sh7fffffff);
    send_word(ACT_SEARCH, 32'sh0);
    send_word(ACT_SEARCH, 32'sh80000000);
    send_word(ACT_SEARCH, 32'sh12345678);
    send_word(ACT_SPARE_7, 32'sh0);
    send_word(ACT_POP_FRONT, 32'sh0);
    send_word(ACT_SEARCH, -32'sd1);
    send_word(ACT_POP_BACK, 32'sh0);
    send_word(ACT_POP_BACK, 32'sh0);
    send_word(ACT_POP_FRONT, 32'sh0);
    send_word(ACT_POP_FRONT, 32'sh0);
    send_word(ACT_SEARCH, 32'sh0);
  endtask

  // Fill to capacity, push into a full store, search it, then drain it
  task automatic test_fill_and_drain();
    while (elem_cnt < DEPTH) begin
      send_word($urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK, rand_value());
    end
    send_word(ACT_PUSH_FRONT, rand_value());
    send_word(ACT_PUSH_BACK, rand_value());
    send_word(ACT_SEARCH, shadow_ring[(head_idx + DEPTH - 1) % DEPTH]);
    send_word(ACT_SEARCH, pick_key());
    while (elem_cnt > 0) begin
      if ($urandom_range(0, 7) == 0) send_word(ACT_SEARCH, pick_key());
      else send_word($urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK, 32'sh0);
    end
    send_word(ACT_POP_BACK, rand_value());
  endtask

  // Random mix in phases that grow, shrink or hold the store level
  task automatic test_random_mix();
    int      sent;
    int      phase_len;
    int      bias;
    int      roll;
    action_t act;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(20, 120);
      bias      = $urandom_range(0, 2);
      repeat (phase_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          act = action_t'($urandom_range(ACT_SPARE_5, ACT_SPARE_7));
        end else if (roll < 35) begin
          act = ACT_SEARCH;
        end else begin
          // grow phases favour pushes, shrink phases favour pops
          case (bias)
            0:       act = ($urandom_range(0, 9) < 8) ? ACT_PUSH_FRONT : ACT_POP_FRONT;
            1:       act = ($urandom_range(0, 9) < 8) ? ACT_POP_FRONT : ACT_PUSH_FRONT;
            default: act = ($urandom_range(0, 1)) ? ACT_PUSH_FRONT : ACT_POP_FRONT;
          endcase
          if ($urandom_range(0, 1)) act = act + 1'b1;
        end
        if (act == ACT_SEARCH) send_word(act, pick_key());
        else send_word(act, rand_value());
        if (act <= ACT_SEARCH) sent++;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_empty_store();
    test_basic_actions();
    test_fill_and_drain();
    test_random_mix();
    test_fill_and_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/rds_pkg.sv
design/rds_ctrl.sv
design/rds_dp.sv
design/ring_deque_with_search.sv
dv/tb_top.sv
